// ----- hdl/gn2d_pkg.sv -----
// ----------------------------------------------------------------------------
// gn2d_pkg: shared constants and types for the 2-D gradient noise core
// Field widths, fixed-point constants and function codes used by the core,
// its checker and the defaults of the core's parameters.
// ----------------------------------------------------------------------------
package gn2d_pkg;

    // Parameter defaults
    localparam int GRID_SIZE_DEF = 256;
    localparam int FRAC_BITS_DEF = 8;

    // Port field widths
    localparam int COORD_W = 16;
    localparam int CELL_W  = 8;
    localparam int OUT_W   = 16;

    // Q0.16 arithmetic
    localparam int Q16_ONE  = 65536;
    localparam int Q16_HALF = 32768;

    // Quintic fade coefficients: 6t^5 - 15t^4 + 10t^3
    localparam int FADE_A = 6;
    localparam int FADE_B = 15;
    localparam int FADE_C = 10;

    // Output saturation limits
    localparam int OUT_MAX = 32767;
    localparam int OUT_MIN = -32768;

    // Function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_EVAL  = 1'b1;

    // Gradient signs: bit 0 is x negative, bit 1 is y negative
    typedef logic [1:0] t_grad;

endpackage

// ----- hdl/gradient_noise_2d_core.sv -----
// ----------------------------------------------------------------------------
// gradient_noise_2d_core: pipelined 2-D gradient noise generator
// Stores one +/-1 gradient pair per grid cell and evaluates quintic-faded,
// bilinearly interpolated gradient noise at Q8.8 points.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (i_valid / o_ready) carries one request per transfer.
//   i_func selects a gradient write (cell_column, cell_row, sign bits) or an
//   evaluation at (x_coord, y_coord). Writes give no result; every
//   evaluation gives one o_noise_value (signed Q1.14) on the output channel
//   (o_valid / i_ready), in request order.
//   Throughput: one request per cycle while the output does not stall,
//   writes and evaluations mixed freely. An evaluation passes six register
//   stages (range reduction, fade powers, table read, dot products and fade,
//   x lerp, y lerp and output), the table read taking the third stage.
//   A write is visible to any evaluation transferred after it.
//   Stall: when the output register is full and i_ready is low the whole
//   pipeline holds, o_ready drops, and nothing is lost or repeated.
//   Reset: synchronous, active low; clears all stage valid bits. The
//   gradient table is not cleared: load every cell an evaluation may touch
//   before evaluating.
// ----------------------------------------------------------------------------
module gradient_noise_2d_core #(
    parameter int GRID_SIZE = gn2d_pkg::GRID_SIZE_DEF,
    parameter int FRAC_BITS = gn2d_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_func,
    input  logic [gn2d_pkg::COORD_W-1:0]       i_x_coord,
    input  logic [gn2d_pkg::COORD_W-1:0]       i_y_coord,
    input  logic [gn2d_pkg::CELL_W-1:0]        i_cell_column,
    input  logic [gn2d_pkg::CELL_W-1:0]        i_cell_row,
    input  logic                               i_grad_x_negative,
    input  logic                               i_grad_y_negative,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [gn2d_pkg::OUT_W-1:0]  o_noise_value
);

    // Index and table geometry
    localparam int XW    = $clog2(GRID_SIZE);
    localparam int DEPTH = GRID_SIZE * GRID_SIZE;
    localparam int AW    = $clog2(DEPTH);

    // Range reduction by reciprocal: floor(v / G) = (v * RM) >> RS, v < 2^VW
    localparam int     VW  = gn2d_pkg::COORD_W;
    localparam int     RS  = VW + XW;
    localparam int     MW  = VW + 1;
    localparam longint RM  = ((longint'(1) << RS) + GRID_SIZE - 1) / GRID_SIZE;
    localparam int     QGW = VW + XW + 1;

    // Arithmetic widths
    localparam int TW   = 16;          // fraction, Q0.16
    localparam int T2W  = 17;          // t^2, t^3 and fade, up to 1.0
    localparam int INW  = 20;          // fade inner polynomial
    localparam int FPW  = T2W + INW + 1;
    localparam int PW   = 19;          // dot products
    localparam int DW1  = PW + 1;
    localparam int LW   = 21;          // first lerp
    localparam int DW2  = LW + 1;
    localparam int PRW1 = T2W + 1 + DW1;
    localparam int PRW2 = T2W + 1 + DW2;
    localparam int RW   = DW2;         // final lerp and scaled result

    logic en;

    // ------------------------------------------------------------------
    // Stage 1: select the values to reduce, start the reciprocal multiply
    // ------------------------------------------------------------------
    logic [VW-1:0]    s0_xv, s0_yv;
    logic [VW+MW-1:0] s0_xp, s0_yp;
    logic [TW-1:0]    s0_tx, s0_ty;

    logic             r_st1_valid, r_st1_eval;
    logic [VW-1:0]    r_st1_xv, r_st1_yv, r_st1_xq, r_st1_yq;
    logic [TW-1:0]    r_st1_tx, r_st1_ty;
    gn2d_pkg::t_grad  r_st1_gs;

    always_comb begin
        if (i_func == gn2d_pkg::FUNC_EVAL) begin
            s0_xv = VW'(i_x_coord >> FRAC_BITS);
            s0_yv = VW'(i_y_coord >> FRAC_BITS);
        end else begin
            s0_xv = VW'(i_cell_column);
            s0_yv = VW'(i_cell_row);
        end
        s0_xp = (VW+MW)'(s0_xv) * (VW+MW)'(MW'(RM));
        s0_yp = (VW+MW)'(s0_yv) * (VW+MW)'(MW'(RM));
        // widen the fraction to Q0.16, integer bits fall off the top
        s0_tx = TW'(i_x_coord << (TW - FRAC_BITS));
        s0_ty = TW'(i_y_coord << (TW - FRAC_BITS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st1_valid <= 1'b0;
        end else if (en) begin
            r_st1_valid <= i_valid;
        end
        if (en) begin
            r_st1_eval <= i_func;
            r_st1_xv   <= s0_xv;
            r_st1_yv   <= s0_yv;
            r_st1_xq   <= VW'(s0_xp >> RS);
            r_st1_yq   <= VW'(s0_yp >> RS);
            r_st1_tx   <= s0_tx;
            r_st1_ty   <= s0_ty;
            r_st1_gs   <= {i_grad_y_negative, i_grad_x_negative};
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: finish the modulo, square the fractions
    // ------------------------------------------------------------------
    logic [QGW-1:0]   s1_xqg, s1_yqg;
    logic [2*TW-1:0]  s1_xsq, s1_ysq;

    logic             r_st2_valid, r_st2_eval;
    logic [XW-1:0]    r_st2_xi, r_st2_yi;
    logic [TW-1:0]    r_st2_tx, r_st2_ty;
    logic [T2W-1:0]   r_st2_tx2, r_st2_ty2;
    gn2d_pkg::t_grad  r_st2_gs;

    always_comb begin
        s1_xqg = QGW'(r_st1_xq) * QGW'(GRID_SIZE);
        s1_yqg = QGW'(r_st1_yq) * QGW'(GRID_SIZE);
        s1_xsq = (2*TW)'(r_st1_tx) * (2*TW)'(r_st1_tx);
        s1_ysq = (2*TW)'(r_st1_ty) * (2*TW)'(r_st1_ty);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st2_valid <= 1'b0;
        end else if (en) begin
            r_st2_valid <= r_st1_valid;
        end
        if (en) begin
            r_st2_eval <= r_st1_eval;
            r_st2_xi   <= XW'(r_st1_xv - VW'(s1_xqg));
            r_st2_yi   <= XW'(r_st1_yv - VW'(s1_yqg));
            r_st2_tx   <= r_st1_tx;
            r_st2_ty   <= r_st1_ty;
            r_st2_tx2  <= T2W'(((2*TW+1)'(s1_xsq)
                                + (2*TW+1)'(gn2d_pkg::Q16_HALF)) >> 16);
            r_st2_ty2  <= T2W'(((2*TW+1)'(s1_ysq)
                                + (2*TW+1)'(gn2d_pkg::Q16_HALF)) >> 16);
            r_st2_gs   <= r_st1_gs;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: corner addresses and table access, t^3 and fade inner term
    // ------------------------------------------------------------------
    logic [XW-1:0]        s2_x1, s2_y1;
    logic [AW-1:0]        s2_a00, s2_a10, s2_a01, s2_a11;
    logic [T2W+TW:0]      s2_x3p, s2_y3p;
    logic [INW:0]         s2_xin, s2_yin;
    logic                 s2_we;
    gn2d_pkg::t_grad      s2_g00, s2_g10, s2_g01, s2_g11;

    logic                 r_st3_valid, r_st3_eval;
    logic [TW-1:0]        r_st3_tx, r_st3_ty;
    logic [T2W-1:0]       r_st3_tx3, r_st3_ty3;
    logic [INW-1:0]       r_st3_xin, r_st3_yin;

    always_comb begin
        // neighbour corner wraps at the grid edge
        s2_x1  = (r_st2_xi == XW'(GRID_SIZE - 1)) ? '0 : r_st2_xi + XW'(1);
        s2_y1  = (r_st2_yi == XW'(GRID_SIZE - 1)) ? '0 : r_st2_yi + XW'(1);
        s2_a00 = AW'(AW'(r_st2_yi) * AW'(GRID_SIZE)) + AW'(r_st2_xi);
        s2_a10 = AW'(AW'(r_st2_yi) * AW'(GRID_SIZE)) + AW'(s2_x1);
        s2_a01 = AW'(AW'(s2_y1) * AW'(GRID_SIZE)) + AW'(r_st2_xi);
        s2_a11 = AW'(AW'(s2_y1) * AW'(GRID_SIZE)) + AW'(s2_x1);
        s2_we  = en && r_st2_valid && (r_st2_eval == gn2d_pkg::FUNC_WRITE);

        s2_x3p = (T2W+TW+1)'(r_st2_tx2) * (T2W+TW+1)'(r_st2_tx);
        s2_y3p = (T2W+TW+1)'(r_st2_ty2) * (T2W+TW+1)'(r_st2_ty);
        // 6t^2 - 15t + 10, always positive over [0, 1)
        s2_xin = (INW+1)'(gn2d_pkg::FADE_A) * (INW+1)'(r_st2_tx2)
               + (INW+1)'(gn2d_pkg::FADE_C * gn2d_pkg::Q16_ONE)
               - (INW+1)'(gn2d_pkg::FADE_B) * (INW+1)'(r_st2_tx);
        s2_yin = (INW+1)'(gn2d_pkg::FADE_A) * (INW+1)'(r_st2_ty2)
               + (INW+1)'(gn2d_pkg::FADE_C * gn2d_pkg::Q16_ONE)
               - (INW+1)'(gn2d_pkg::FADE_B) * (INW+1)'(r_st2_ty);
    end

    // Two copies of the table: one serves the lower row of corners, one the
    // upper; every write goes to both.
    gn2d_ram #(
        .WIDTH ($bits(gn2d_pkg::t_grad)),
        .DEPTH (DEPTH)
    ) u_ram_lo (
        .i_clk     (i_clk),
        .i_we      (s2_we),
        .i_waddr   (s2_a00),
        .i_wdata   (r_st2_gs),
        .i_re      (en),
        .i_raddr_a (s2_a00),
        .i_raddr_b (s2_a10),
        .o_rdata_a (s2_g00),
        .o_rdata_b (s2_g10)
    );

    gn2d_ram #(
        .WIDTH ($bits(gn2d_pkg::t_grad)),
        .DEPTH (DEPTH)
    ) u_ram_hi (
        .i_clk     (i_clk),
        .i_we      (s2_we),
        .i_waddr   (s2_a00),
        .i_wdata   (r_st2_gs),
        .i_re      (en),
        .i_raddr_a (s2_a01),
        .i_raddr_b (s2_a11),
        .o_rdata_a (s2_g01),
        .o_rdata_b (s2_g11)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st3_valid <= 1'b0;
        end else if (en) begin
            r_st3_valid <= r_st2_valid;
        end
        if (en) begin
            r_st3_eval <= r_st2_eval;
            r_st3_tx   <= r_st2_tx;
            r_st3_ty   <= r_st2_ty;
            r_st3_tx3  <= T2W'(((T2W+TW+1)'(s2_x3p)
                                + (T2W+TW+1)'(gn2d_pkg::Q16_HALF)) >> 16);
            r_st3_ty3  <= T2W'(((T2W+TW+1)'(s2_y3p)
                                + (T2W+TW+1)'(gn2d_pkg::Q16_HALF)) >> 16);
            r_st3_xin  <= INW'(s2_xin);
            r_st3_yin  <= INW'(s2_yin);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: corner dot products, fade weights; drop write items here
    // ------------------------------------------------------------------
    function automatic logic signed [PW-1:0] corner_dot(
        input gn2d_pkg::t_grad       g,
        input logic signed [PW-1:0]  dx,
        input logic signed [PW-1:0]  dy
    );
        logic signed [PW-1:0] px;
        logic signed [PW-1:0] py;
        px = g[0] ? -dx : dx;
        py = g[1] ? -dy : dy;
        return px + py;
    endfunction

    logic signed [PW-1:0] s3_dx0, s3_dx1, s3_dy0, s3_dy1;
    logic [FPW-1:0]       s3_fxp, s3_fyp;
    logic [FPW-17:0]      s3_fxr, s3_fyr;

    logic                 r_st4_valid;
    logic signed [PW-1:0] r_st4_p0, r_st4_p1, r_st4_p2, r_st4_p3;
    logic [T2W-1:0]       r_st4_fx, r_st4_fy;

    always_comb begin
        s3_dx0 = $signed(PW'(r_st3_tx));
        s3_dy0 = $signed(PW'(r_st3_ty));
        s3_dx1 = s3_dx0 - PW'(gn2d_pkg::Q16_ONE);
        s3_dy1 = s3_dy0 - PW'(gn2d_pkg::Q16_ONE);
        s3_fxp = FPW'(r_st3_tx3) * FPW'(r_st3_xin) + FPW'(gn2d_pkg::Q16_HALF);
        s3_fyp = FPW'(r_st3_ty3) * FPW'(r_st3_yin) + FPW'(gn2d_pkg::Q16_HALF);
        s3_fxr = (FPW-16)'(s3_fxp >> 16);
        s3_fyr = (FPW-16)'(s3_fyp >> 16);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st4_valid <= 1'b0;
        end else if (en) begin
            r_st4_valid <= r_st3_valid && (r_st3_eval == gn2d_pkg::FUNC_EVAL);
        end
        if (en) begin
            r_st4_p0 <= corner_dot(s2_g00, s3_dx0, s3_dy0);
            r_st4_p1 <= corner_dot(s2_g10, s3_dx1, s3_dy0);
            r_st4_p2 <= corner_dot(s2_g01, s3_dx0, s3_dy1);
            r_st4_p3 <= corner_dot(s2_g11, s3_dx1, s3_dy1);
            // clamp the fade at one
            r_st4_fx <= (s3_fxr > (FPW-16)'(gn2d_pkg::Q16_ONE)) ?
                        T2W'(gn2d_pkg::Q16_ONE) : T2W'(s3_fxr);
            r_st4_fy <= (s3_fyr > (FPW-16)'(gn2d_pkg::Q16_ONE)) ?
                        T2W'(gn2d_pkg::Q16_ONE) : T2W'(s3_fyr);
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: lerp along x for the lower and upper rows
    // ------------------------------------------------------------------
    logic signed [DW1-1:0]  s4_d1, s4_d2;
    logic signed [PRW1-1:0] s4_m1, s4_m2;

    logic                   r_st5_valid;
    logic signed [LW-1:0]   r_st5_l1, r_st5_l2;
    logic [T2W-1:0]         r_st5_fy;

    always_comb begin
        s4_d1 = DW1'(r_st4_p1) - DW1'(r_st4_p0);
        s4_d2 = DW1'(r_st4_p3) - DW1'(r_st4_p2);
        s4_m1 = $signed({1'b0, r_st4_fx}) * s4_d1 + PRW1'(gn2d_pkg::Q16_HALF);
        s4_m2 = $signed({1'b0, r_st4_fx}) * s4_d2 + PRW1'(gn2d_pkg::Q16_HALF);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st5_valid <= 1'b0;
        end else if (en) begin
            r_st5_valid <= r_st4_valid;
        end
        if (en) begin
            r_st5_l1 <= LW'(r_st4_p0) + LW'(s4_m1 >>> 16);
            r_st5_l2 <= LW'(r_st4_p2) + LW'(s4_m2 >>> 16);
            r_st5_fy <= r_st4_fy;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: lerp along y, scale Q.16 down to Q1.14, saturate
    // ------------------------------------------------------------------
    logic signed [DW2-1:0]  s5_d;
    logic signed [PRW2-1:0] s5_m;
    logic signed [RW-1:0]   s5_l3, s5_q;
    logic signed [gn2d_pkg::OUT_W-1:0] n_out_value;

    logic                   r_out_valid;
    logic signed [gn2d_pkg::OUT_W-1:0] r_out_value;

    always_comb begin
        s5_d  = DW2'(r_st5_l2) - DW2'(r_st5_l1);
        s5_m  = $signed({1'b0, r_st5_fy}) * s5_d + PRW2'(gn2d_pkg::Q16_HALF);
        s5_l3 = RW'(r_st5_l1) + RW'(s5_m >>> 16);
        // floor((l + 2) / 4)
        s5_q  = (s5_l3 + RW'(2)) >>> 2;
        if (s5_q > RW'(gn2d_pkg::OUT_MAX)) begin
            n_out_value = gn2d_pkg::OUT_W'(gn2d_pkg::OUT_MAX);
        end else if (s5_q < RW'(gn2d_pkg::OUT_MIN)) begin
            n_out_value = gn2d_pkg::OUT_W'(gn2d_pkg::OUT_MIN);
        end else begin
            n_out_value = gn2d_pkg::OUT_W'(s5_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_st5_valid;
        end
        if (en) begin
            r_out_value <= n_out_value;
        end
    end

    // Advance every stage whenever the output register is free or drains
    assign en            = !r_out_valid || i_ready;
    assign o_ready       = en;
    assign o_valid       = r_out_valid;
    assign o_noise_value = r_out_value;

endmodule

// ----- hdl/gn2d_ram.sv -----
// ----------------------------------------------------------------------------
// gn2d_ram: generic RAM, one write port and two registered read ports
// Read data is registered and only advances while the read enable is high.
// ----------------------------------------------------------------------------
module gn2d_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 65536,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ----- hdl/gn2d_checker.sv -----
// ----------------------------------------------------------------------------
// gn2d_checker: port-level checks for the 2-D gradient noise core
// Watches only the core's ports; attached to every core instance by bind.
// ----------------------------------------------------------------------------
module gn2d_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_ready,
    input logic                              i_func,
    input logic                              o_valid,
    input logic                              i_ready,
    input logic [gn2d_pkg::OUT_W-1:0]        o_noise_value
);

    // Hold the result while the receiver stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(o_noise_value))
        else $error("result changed while stalled");

    // An empty output register never blocks the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked with output empty");

    // An evaluation reaches the output while the receiver keeps ready high
    a_eval_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_func == gn2d_pkg::FUNC_EVAL)
        ##1 i_ready ##1 i_ready ##1 i_ready ##1 i_ready ##1 i_ready
        |=> o_valid)
        else $error("evaluation result late");

endmodule

bind gradient_noise_2d_core gn2d_checker u_gn2d_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .i_func        (i_func),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_noise_value (o_noise_value)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for gradient_noise_2d_core
// Loads gradient cells, evaluates noise at points whose four corners are all
// loaded, and checks every noise result against a bit-exact fixed-point
// predictor of the gradient noise datapath. Both channels idle and stall at
// random.
// ----------------------------------------------------------------------------
module tb;

    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int END_HOLD         = 20;
    localparam int PHASES           = 6;
    localparam int WINDOW_SPAN      = 5;
    localparam int ITEMS_PER_PHASE  = 65;
    localparam int REPORT_LINES     = 20;
    localparam int EVAL_TRIES       = 16;

    // Cells either side of the grid seam, used by the directed part
    localparam logic [7:0] WRAP_CELLS [4] = '{8'd254, 8'd255, 8'd0, 8'd1};

    // One outstanding evaluation and the noise it should return
    typedef struct {
        logic [15:0]        x;
        logic [15:0]        y;
        logic signed [15:0] noise;
    } t_noise_due;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the gradient table and predicts each noise value
    // ------------------------------------------------------------------------
    class t_noise_scoreboard;
        gn2d_pkg::t_grad grad_tab [65536];
        bit              cell_loaded [65536];
        t_noise_due      noise_due [$];

        // Round half up from Q.32 to Q.16; the shift is arithmetic, so floor
        function longint round_q16(longint v);
            return (v + gn2d_pkg::Q16_HALF) >>> 16;
        endfunction

        function longint fade_q16(longint t);
            longint t2;
            longint t3;
            longint inner;
            longint f;
            t2 = round_q16(t * t);
            t3 = round_q16(t2 * t);
            inner = gn2d_pkg::FADE_A * t2 - gn2d_pkg::FADE_B * t
                    + gn2d_pkg::FADE_C * longint'(gn2d_pkg::Q16_ONE);
            f = round_q16(t3 * inner);
            if (f > gn2d_pkg::Q16_ONE)
                f = gn2d_pkg::Q16_ONE;
            if (f < 0)
                f = 0;
            return f;
        endfunction

        function longint lerp_q16(longint a, longint b, longint w);
            return a + round_q16(w * (b - a));
        endfunction

        function longint corner_dot(logic [7:0] col, logic [7:0] row,
                                    longint dx, longint dy);
            gn2d_pkg::t_grad g;
            longint px;
            longint py;
            g  = grad_tab[{row, col}];
            px = g[0] ? -dx : dx;
            py = g[1] ? -dy : dy;
            return px + py;
        endfunction

        function logic signed [15:0] predict_noise(logic [15:0] x, logic [15:0] y);
            logic [7:0] xi;
            logic [7:0] yi;
            logic [7:0] xn;
            logic [7:0] yn;
            longint     one;
            longint     tx;
            longint     ty;
            longint     fx;
            longint     fy;
            longint     top;
            longint     bot;
            longint     mix;
            longint     q;
            one = gn2d_pkg::Q16_ONE;
            xi  = x[15:8];
            yi  = y[15:8];
            xn  = xi + 8'd1;
            yn  = yi + 8'd1;
            tx  = longint'({x[7:0], 8'h00});
            ty  = longint'({y[7:0], 8'h00});
            fx  = fade_q16(tx);
            fy  = fade_q16(ty);
            top = lerp_q16(corner_dot(xi, yi, tx, ty),
                           corner_dot(xn, yi, tx - one, ty), fx);
            bot = lerp_q16(corner_dot(xi, yn, tx, ty - one),
                           corner_dot(xn, yn, tx - one, ty - one), fx);
            mix = lerp_q16(top, bot, fy);
            q   = (mix + 2) >>> 2;
            if (q > gn2d_pkg::OUT_MAX)
                q = gn2d_pkg::OUT_MAX;
            if (q < gn2d_pkg::OUT_MIN)
                q = gn2d_pkg::OUT_MIN;
            return q[15:0];
        endfunction

        function bit corners_loaded(logic [15:0] x, logic [15:0] y);
            logic [7:0] xi;
            logic [7:0] yi;
            logic [7:0] xn;
            logic [7:0] yn;
            xi = x[15:8];
            yi = y[15:8];
            xn = xi + 8'd1;
            yn = yi + 8'd1;
            return cell_loaded[{yi, xi}] && cell_loaded[{yi, xn}] &&
                   cell_loaded[{yn, xi}] && cell_loaded[{yn, xn}];
        endfunction

        function void note_request(logic func, logic [15:0] x, logic [15:0] y,
                                   logic [7:0] col, logic [7:0] row,
                                   logic gx, logic gy);
            t_noise_due due;
            if (func == gn2d_pkg::FUNC_WRITE) begin
                grad_tab[{row, col}]    = {gy, gx};
                cell_loaded[{row, col}] = 1'b1;
            end else begin
                due.x     = x;
                due.y     = y;
                due.noise = predict_noise(x, y);
                noise_due.push_back(due);
            end
        endfunction

        function bit check_noise(logic signed [15:0] got, output string msg);
            t_noise_due due;
            msg = "";
            if (noise_due.size() == 0) begin
                msg = $sformatf("noise result %0d with no evaluation outstanding", got);
                return 1'b0;
            end
            due = noise_due.pop_front();
            if (got !== due.noise) begin
                msg = $sformatf("noise at x=%h y=%h: got %0d, expected %0d",
                                due.x, due.y, got, due.noise);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function int pending();
            return noise_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic        i_valid           = 1'b0;
    logic        o_ready;
    logic        i_func            = gn2d_pkg::FUNC_WRITE;
    logic [15:0] i_x_coord         = '0;
    logic [15:0] i_y_coord         = '0;
    logic [7:0]  i_cell_column     = '0;
    logic [7:0]  i_cell_row        = '0;
    logic        i_grad_x_negative = 1'b0;
    logic        i_grad_y_negative = 1'b0;
    logic        o_valid;
    logic        i_ready           = 1'b0;
    logic signed [15:0] o_noise_value;

    t_noise_scoreboard board;
    int    mismatches = 0;
    int    idle_cycles = 0;
    int    rx_hold = 0;
    bit    tx_burst = 1'b0;    // sender offers back to back when set
    bit    rx_burst = 1'b0;    // receiver never stalls when set
    string verdict;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    gradient_noise_2d_core uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_func            (i_func),
        .i_x_coord         (i_x_coord),
        .i_y_coord         (i_y_coord),
        .i_cell_column     (i_cell_column),
        .i_cell_row        (i_cell_row),
        .i_grad_x_negative (i_grad_x_negative),
        .i_grad_y_negative (i_grad_y_negative),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_noise_value     (o_noise_value)
    );

    // Print a mismatch (only the first few) and count every one
    task automatic report_mismatch(input string msg);
        if (mismatches < REPORT_LINES)
            $display("ERROR at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    // Idle for a drawn gap, offer one request, hold it until the transfer,
    // then record it in the scoreboard. Recording here, not in a monitor,
    // keeps the table mirror current before the next request is chosen.
    task automatic send_request(input logic func, input logic [15:0] x,
                                input logic [15:0] y, input logic [7:0] col,
                                input logic [7:0] row, input logic gx,
                                input logic gy);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_func            <= func;
        i_x_coord         <= x;
        i_y_coord         <= y;
        i_cell_column     <= col;
        i_cell_row        <= row;
        i_grad_x_negative <= gx;
        i_grad_y_negative <= gy;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_request(func, x, y, col, row, gx, gy);
    endtask

    // Write one cell; the unused coordinate fields carry noise
    task automatic send_write(input logic [7:0] col, input logic [7:0] row,
                              input logic gx, input logic gy);
        send_request(gn2d_pkg::FUNC_WRITE, 16'($urandom), 16'($urandom),
                     col, row, gx, gy);
    endtask

    // Evaluate one point; the unused cell fields carry noise
    task automatic send_eval(input logic [15:0] x, input logic [15:0] y);
        send_request(gn2d_pkg::FUNC_EVAL, x, y, 8'($urandom), 8'($urandom),
                     1'($urandom), 1'($urandom));
    endtask

    // Fraction with a bias towards the fade end points
    function automatic logic [7:0] pick_frac();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return 8'h00;
        if (sel == 1)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    // Load every cell of a window so that points inside it can be evaluated
    task automatic load_window(input logic [7:0] base_x, input logic [7:0] base_y);
        for (int j = 0; j < WINDOW_SPAN; j++) begin
            for (int i = 0; i < WINDOW_SPAN; i++)
                send_write(base_x + 8'(i), base_y + 8'(j), 1'($urandom), 1'($urandom));
        end
    endtask

    // One random request: mostly evaluations inside the loaded window,
    // some rewrites of it, some writes and points anywhere on the grid.
    // A point is only sent once all four of its corners hold a gradient.
    task automatic random_item(input logic [7:0] base_x, input logic [7:0] base_y);
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  xi;
        logic [7:0]  yi;
        bit          found;
        if ($urandom_range(0, 99) < 35) begin
            if ($urandom_range(0, 3) == 0)
                send_write(8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
            else
                send_write(base_x + 8'($urandom_range(0, WINDOW_SPAN - 1)),
                           base_y + 8'($urandom_range(0, WINDOW_SPAN - 1)),
                           1'($urandom), 1'($urandom));
        end else begin
            found = 1'b0;
            for (int tries = 0; tries < EVAL_TRIES && !found; tries++) begin
                if ($urandom_range(0, 3) == 0) begin
                    x = 16'($urandom);
                    y = 16'($urandom);
                end else begin
                    xi = base_x + 8'($urandom_range(0, WINDOW_SPAN - 2));
                    yi = base_y + 8'($urandom_range(0, WINDOW_SPAN - 2));
                    x  = {xi, pick_frac()};
                    y  = {yi, pick_frac()};
                end
                found = board.corners_loaded(x, y);
            end
            if (found)
                send_eval(x, y);
            else
                send_write(base_x, base_y, 1'($urandom), 1'($urandom));
        end
    endtask

    // Drop valid and hold off until every outstanding noise result is back
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver side and result check
    // ------------------------------------------------------------------------
    // After each transfer draw a stall length; hold ready low while it counts
    // down, then raise it and keep it high until the next transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (!board.check_noise(o_noise_value, verdict))
                report_mismatch(verdict);
            rx_hold = rx_burst ? 0 : $urandom_range(0, 10);
            if (rx_hold > 0)
                i_ready <= 1'b0;
        end else if (!i_ready) begin
            if (rx_hold == 0)
                i_ready <= 1'b1;
            else
                rx_hold--;
        end
    end

    // Watchdog: end the run if neither channel moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("gradient_noise_2d_core: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [7:0] base_x;
        logic [7:0] base_y;
        board = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Load a 4x4 block across the grid seam. Signs follow cell parity,
        // so the cell at (254,254) sees all four gradients pointing inwards
        // and the cell at (255,255) all four pointing outwards.
        foreach (WRAP_CELLS[r]) begin
            foreach (WRAP_CELLS[c])
                send_write(WRAP_CELLS[c], WRAP_CELLS[r], WRAP_CELLS[c][0],
                           WRAP_CELLS[r][0]);
        end

        send_eval(16'hFE80, 16'hFE80);   // centre of an inward cell: +1.0
        send_eval(16'hFF80, 16'hFF80);   // centre across both seams: -1.0
        send_eval(16'h0000, 16'h0000);   // zero fraction, fade at zero
        send_eval(16'hFFFF, 16'hFFFF);   // top of the range, both axes wrap
        send_eval(16'hFEFF, 16'h0000);
        send_eval(16'h0080, 16'hFF40);   // y corner wraps from 255 to 0
        send_eval(16'hFE01, 16'h00FF);

        // Rewrite a corner and evaluate straight after: the new signs apply
        send_write(8'd255, 8'd255, 1'b0, 1'b0);
        send_eval(16'hFF80, 16'hFF80);

        // Random phases, each on a freshly loaded window. The first window
        // straddles the seam; the sender and receiver modes vary by phase,
        // with one phase running at full rate on both sides.
        for (int phase = 0; phase < PHASES; phase++) begin
            base_x   = (phase == 0) ? 8'd253 : 8'($urandom);
            base_y   = (phase == 0) ? 8'd253 : 8'($urandom);
            tx_burst = (phase == 2) || (phase == 4);
            rx_burst = (phase == 3) || (phase == 4);
            load_window(base_x, base_y);
            repeat (ITEMS_PER_PHASE) random_item(base_x, base_y);
            drain_results();
        end

        // Hold a little longer to catch any stray result
        repeat (END_HOLD) @(posedge i_clk);
        if (mismatches == 0 && board.pending() == 0)
            $display("gradient_noise_2d_core: match");
        else
            $display("gradient_noise_2d_core: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/gn2d_pkg.sv
hdl/gn2d_ram.sv
hdl/gradient_noise_2d_core.sv
hdl/gn2d_checker.sv
tb/sv/tb.sv
